[sv/pee_pkg.sv]
// shared types and constants for the prefix expression evaluator
// no dependencies
package pee_pkg;

  localparam int WORD_W = 32;

  typedef logic [WORD_W-1:0] word_t;

  // operator character codes
  localparam logic [7:0] SYM_PLUS  = 8'h2B;
  localparam logic [7:0] SYM_MINUS = 8'h2D;
  localparam logic [7:0] SYM_STAR  = 8'h2A;
  localparam logic [7:0] SYM_SLASH = 8'h2F;
  localparam logic [7:0] SYM_XOR   = 8'h5E;

  localparam word_t DIGIT_BIAS = 32'd48;
  localparam word_t EMPTY_VAL  = 32'hFFFF_FFFF;

  // shift control shared by every stack cell
  typedef struct packed {
    logic push;
    logic pop;
  } stk_ctl_t;

  function automatic logic is_operator(input logic [7:0] sym);
    is_operator = (sym == SYM_PLUS) || (sym == SYM_MINUS) || (sym == SYM_STAR) ||
                  (sym == SYM_SLASH) || (sym == SYM_XOR);
  endfunction

endpackage

[sv/prefix_expression_evaluator.sv]
// Prefix expression evaluator: characters arrive right to left, one per transfer, and are
// evaluated on a stack built as a chain of STACK_DEPTH cells with the top in cell 0. An
// operand character is pushed as it is taken. An operator steps through transfer, pop,
// pop, compute and push; a division by a nonzero value runs the bit-serial divider, one
// quotient bit per cycle, before the push. The character marked last then pops the final
// value into the output register, after any wait until that register has been taken.
// Depends on pee_pkg, pee_cell and pee_div.
module prefix_expression_evaluator
  import pee_pkg::*;
#(
  parameter int STACK_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  symbol,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] value,
  output logic        underflow,
  output logic        overflow,
  output logic        div_zero
);

  localparam int CW = $clog2(STACK_DEPTH + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_POPA = 3'd1;
  localparam logic [2:0] S_POPB = 3'd2;
  localparam logic [2:0] S_OP   = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_PUSH = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0]    state;
  logic [CW-1:0] count;
  logic          underflow_seen;
  logic          overflow_seen;
  logic          div_zero_seen;
  logic [7:0]    op_sym;
  logic          op_last;
  word_t         opa;
  word_t         opb;
  word_t         res;

  logic     in_xfer;
  logic     empty;
  logic     full;
  logic     push_req;
  logic     pop_req;
  word_t    push_val;
  word_t    top_val;
  stk_ctl_t ctl;
  logic     div_start;
  logic     div_done;
  word_t    div_q;
  logic     fin_go;

  word_t cell_data [STACK_DEPTH];

  assign in_ready = (state == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign empty    = (count == '0);
  assign full     = (count == CW'(STACK_DEPTH));
  assign top_val  = empty ? EMPTY_VAL : cell_data[0];
  assign fin_go   = (state == S_FIN) && (!out_valid || out_ready);

  always_comb begin
    push_req = 1'b0;
    pop_req  = 1'b0;
    push_val = res;
    if (in_xfer && !is_operator(symbol)) begin
      push_req = 1'b1;
      push_val = {{(WORD_W-8){1'b0}}, symbol} - DIGIT_BIAS;
    end else if (state == S_PUSH) begin
      push_req = 1'b1;
    end else if (state == S_POPA || state == S_POPB) begin
      pop_req = 1'b1;
    end
    ctl.push = push_req && !full;
    ctl.pop  = pop_req && !empty;
  end

  // cell 0 is the top of stack; a push shifts every cell down by one cell at once
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    word_t above;
    word_t below;
    if (i == 0) begin : g_top
      assign above = push_val;
    end else begin : g_mid
      assign above = cell_data[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bot
      assign below = cell_data[i];
    end else begin : g_up
      assign below = cell_data[i+1];
    end
    pee_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .from_above (above),
      .from_below (below),
      .data       (cell_data[i])
    );
  end

  pee_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (opa),
    .divisor  (opb),
    .done     (div_done),
    .quotient (div_q)
  );

  assign div_start = (state == S_OP) && (op_sym == SYM_SLASH) && (opb != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      count          <= '0;
      underflow_seen <= 1'b0;
      overflow_seen  <= 1'b0;
      div_zero_seen  <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (fin_go) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (ctl.push) begin
        count <= count + 1'b1;
      end else if (ctl.pop) begin
        count <= count - 1'b1;
      end
      if (push_req && full) begin
        overflow_seen <= 1'b1;
      end
      if (pop_req && empty) begin
        underflow_seen <= 1'b1;
      end

      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            op_sym  <= symbol;
            op_last <= last;
            if (is_operator(symbol)) begin
              state <= S_POPA;
            end else if (last) begin
              state <= S_FIN;
            end
          end
        end
        S_POPA: begin
          opa   <= top_val;
          state <= S_POPB;
        end
        S_POPB: begin
          opb   <= top_val;
          state <= S_OP;
        end
        S_OP: begin
          state <= div_start ? S_DIV : S_PUSH;
          unique case (op_sym)
            SYM_PLUS:  res <= opa + opb;
            SYM_MINUS: res <= opa - opb;
            SYM_STAR:  res <= opa * opb;
            SYM_SLASH: begin
              if (opb == '0) begin
                res           <= '0;
                div_zero_seen <= 1'b1;
              end
            end
            default:   res <= opa ^ opb;
          endcase
        end
        S_DIV: begin
          if (div_done) begin
            res   <= div_q;
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          state <= op_last ? S_FIN : S_IDLE;
        end
        S_FIN: begin
          if (fin_go) begin
            count          <= '0;
            underflow_seen <= 1'b0;
            overflow_seen  <= 1'b0;
            div_zero_seen  <= 1'b0;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result payload, loaded together with the final pop
  always_ff @(posedge clk) begin
    if (fin_go) begin
      value     <= top_val;
      underflow <= underflow_seen || empty;
      overflow  <= overflow_seen;
      div_zero  <= div_zero_seen;
    end
  end

endmodule

[sv/pee_cell.sv]
// one stack entry; shifts down on push, up on pop
// depends on pee_pkg
module pee_cell
  import pee_pkg::*;
(
  input  logic     clk,
  input  stk_ctl_t ctl,
  input  word_t    from_above,
  input  word_t    from_below,
  output word_t    data
);

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      data <= from_above;
    end else if (ctl.pop) begin
      data <= from_below;
    end
  end

endmodule

[sv/pee_div.sv]
// signed 32-bit divider, truncating toward zero, one quotient bit per cycle
// depends on pee_pkg
module pee_div
  import pee_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  word_t dividend,
  input  word_t divisor,
  output logic  done,
  output word_t quotient
);

  logic                      busy;
  logic                      fix;
  logic [$clog2(WORD_W)-1:0] cnt;
  word_t                     dvd;
  word_t                     dvs;
  word_t                     rem;
  logic                      neg;
  logic [WORD_W:0]           shifted;
  logic [WORD_W:0]           diff;
  logic                      ge;

  assign shifted = {rem, dvd[WORD_W-1]};
  assign diff    = shifted - {1'b0, dvs};
  assign ge      = !diff[WORD_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fix  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= fix;
      if (start) begin
        dvd  <= dividend[WORD_W-1] ? (WORD_W)'(0) - dividend : dividend;
        dvs  <= divisor[WORD_W-1] ? (WORD_W)'(0) - divisor : divisor;
        neg  <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
        rem  <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem <= ge ? diff[WORD_W-1:0] : shifted[WORD_W-1:0];
        dvd <= {dvd[WORD_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == '1) begin
          busy <= 1'b0;
          fix  <= 1'b1;
        end
      end else if (fix) begin
        fix      <= 1'b0;
        quotient <= neg ? (WORD_W)'(0) - dvd : dvd;
      end
    end
  end

endmodule

[sv/pee_checker.sv]
// port-level checks for the prefix expression evaluator
// bound onto prefix_expression_evaluator; depends on pee_pkg
module pee_checker
  import pee_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  symbol,
  input logic        last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] value,
  input logic        underflow,
  input logic        overflow,
  input logic        div_zero
);

  // nothing to report straight out of reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  // a waiting result holds still
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(value) && $stable(underflow) &&
                                $stable(overflow) && $stable(div_zero))
    else $error("result changed while stalled");

  // the closing character always keeps the input side busy for the final pop
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last |=> !in_ready)
    else $error("input taken right after the last character");

  // an operator transfer starts a multi-cycle evaluation
  a_op_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && is_operator(symbol) |=> !in_ready)
    else $error("input taken right after an operator");

  // a new result only comes out of the final-pop step, when input is blocked
  a_result_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while input side was open");

endmodule

bind prefix_expression_evaluator pee_checker u_pee_checker (.*);

[bench/tb_prefix_expression_evaluator.sv]
// self-checking bench for prefix_expression_evaluator: directed table then random expressions
// results are predicted by a local stack evaluator and compared in order at the output
// depends on pee_pkg and the evaluator rtl
module tb_prefix_expression_evaluator;
  import pee_pkg::*;

  localparam int STACK_DEPTH   = 16;
  localparam int ITEM_TARGET   = 1850;
  localparam int TAIL_ITEMS    = 200;
  localparam int DRAIN_CYCLES  = 60;
  localparam int LIMIT_CYCLES  = 600_000;
  localparam logic [7:0] DIGIT0 = 8'h30;

  typedef struct packed {
    word_t value;
    logic  uf;
    logic  ovf;
    logic  dz;
  } answer_t;

  typedef struct {
    logic [7:0] sym;
    bit         lst;
    bit         typed;
    answer_t    ans;
  } row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  symbol = 8'h00;
  logic        last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] value;
  logic        underflow;
  logic        overflow;
  logic        div_zero;

  // local copy of the evaluator state
  word_t       calc_stack [STACK_DEPTH];
  int          calc_depth = 0;
  bit          uf_seen = 0;
  bit          ovf_seen = 0;
  bit          dz_seen = 0;

  answer_t     pending_answers [$];
  row_t        directed_rows [$];
  logic [7:0]  expr_syms [$];
  logic [7:0]  op_codes [5] = '{SYM_PLUS, SYM_MINUS, SYM_STAR, SYM_SLASH, SYM_XOR};

  int          errors = 0;
  int          items_sent = 0;
  int          expressions = 0;
  int          answers_checked = 0;
  int          uf_answers = 0;
  int          ovf_answers = 0;
  int          dz_answers = 0;
  int          gap_pct = 0;
  int          cycles = 0;
  bit          quiet_tail = 0;

  prefix_expression_evaluator #(.STACK_DEPTH(STACK_DEPTH)) u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .symbol   (symbol),
    .last     (last),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .value    (value),
    .underflow(underflow),
    .overflow (overflow),
    .div_zero (div_zero)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d answers still awaited", cycles,
               pending_answers.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic stack_push(input word_t v);
    if (calc_depth >= STACK_DEPTH) begin
      ovf_seen = 1;
    end else begin
      calc_stack[calc_depth] = v;
      calc_depth++;
    end
  endtask

  task automatic stack_pop(output word_t v);
    if (calc_depth == 0) begin
      uf_seen = 1;
      v = EMPTY_VAL;
    end else begin
      calc_depth--;
      v = calc_stack[calc_depth];
    end
  endtask

  // signed divide truncated toward zero, worked on magnitudes so min / -1 wraps
  function automatic word_t trunc_div(input word_t num, input word_t den);
    word_t mn, md, q;
    mn = num[WORD_W-1] ? -num : num;
    md = den[WORD_W-1] ? -den : den;
    q = mn / md;
    return (num[WORD_W-1] ^ den[WORD_W-1]) ? -q : q;
  endfunction

  task automatic eval_symbol(input logic [7:0] sym, input bit lst, output bit done,
                             output answer_t ans);
    word_t a, b, r;
    done = 0;
    ans = '0;
    if (sym inside {SYM_PLUS, SYM_MINUS, SYM_STAR, SYM_SLASH, SYM_XOR}) begin
      stack_pop(a);
      stack_pop(b);
      case (sym)
        SYM_PLUS:  r = a + b;
        SYM_MINUS: r = a - b;
        SYM_STAR:  r = a * b;
        SYM_SLASH: begin
          if (b == '0) begin
            dz_seen = 1;
            r = '0;
          end else begin
            r = trunc_div(a, b);
          end
        end
        default:   r = a ^ b;
      endcase
      stack_push(r);
    end else begin
      stack_push(word_t'(sym) - DIGIT_BIAS);
    end
    if (lst) begin
      stack_pop(r);
      ans = '{value: r, uf: uf_seen, ovf: ovf_seen, dz: dz_seen};
      done = 1;
      calc_depth = 0;
      uf_seen = 0;
      ovf_seen = 0;
      dz_seen = 0;
    end
  endtask

  task automatic send_item(input logic [7:0] sym, input bit lst, input bit typed,
                           input answer_t typed_ans);
    bit done;
    answer_t ans;
    in_valid <= 1'b1;
    symbol <= sym;
    last <= lst;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    eval_symbol(sym, lst, done, ans);
    if (done) pending_answers.push_back(typed ? typed_ans : ans);
    if (!quiet_tail && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic add_row(input logic [7:0] sym, input bit lst);
    directed_rows.push_back('{sym: sym, lst: lst, typed: 0, ans: '0});
  endtask

  task automatic add_typed(input logic [7:0] sym, input answer_t ans);
    directed_rows.push_back('{sym: sym, lst: 1, typed: 1, ans: ans});
  endtask

  function automatic logic [7:0] rand_operator();
    return op_codes[$urandom_range(0, 4)];
  endfunction

  function automatic logic [7:0] rand_operand();
    logic [7:0] s;
    if ($urandom_range(0, 4) == 0) begin
      do s = 8'($urandom_range(0, 255));
      while (s inside {SYM_PLUS, SYM_MINUS, SYM_STAR, SYM_SLASH, SYM_XOR});
      return s;
    end
    return DIGIT0 + 8'($urandom_range(0, 9));
  endfunction

  // fills expr_syms in feed order (rightmost character first)
  task automatic build_expression();
    int kind, n_opnd, placed, depth, len, pos;
    bit deep;
    expr_syms.delete();
    kind = $urandom_range(0, 99);
    if (kind < 70 || kind >= 85) begin
      deep = ($urandom_range(0, 9) == 0);
      n_opnd = deep ? $urandom_range(12, 20) : $urandom_range(1, 8);
      placed = 0;
      depth = 0;
      while (placed < n_opnd || depth > 1) begin
        if (depth >= 2 && (placed == n_opnd || (!deep && $urandom_range(0, 2) == 0))) begin
          expr_syms.push_back(rand_operator());
          depth--;
        end else begin
          expr_syms.push_back(rand_operand());
          placed++;
          depth++;
        end
      end
      if (kind >= 85) begin
        // broken sequence: stray operator, missing character or stray operand
        pos = $urandom_range(0, expr_syms.size() - 1);
        case ($urandom_range(0, 2))
          0: expr_syms.insert(pos, rand_operator());
          1: if (expr_syms.size() > 1) expr_syms.delete(pos);
          default: expr_syms.insert(pos, rand_operand());
        endcase
      end
    end else begin
      len = $urandom_range(1, 8);
      repeat (len) expr_syms.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    forever begin
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_answers
    answer_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_answers.size() == 0) begin
        $error("answer with none awaited: value %0d", $signed(value));
        errors++;
      end else begin
        e = pending_answers.pop_front();
        answers_checked++;
        if (underflow) uf_answers++;
        if (overflow) ovf_answers++;
        if (div_zero) dz_answers++;
        if (value !== e.value) begin
          $error("value: expected %0d, got %0d", $signed(e.value), $signed(value));
          errors++;
        end
        if (underflow !== e.uf) begin
          $error("underflow: expected %0b, got %0b", e.uf, underflow);
          errors++;
        end
        if (overflow !== e.ovf) begin
          $error("overflow: expected %0b, got %0b", e.ovf, overflow);
          errors++;
        end
        if (div_zero !== e.dz) begin
          $error("div_zero: expected %0b, got %0b", e.dz, div_zero);
          errors++;
        end
      end
    end
  end

  initial begin : stimulus
    answer_t none;
    none = '0;

    // operators on an empty stack: each one underflows on at least one pop, each result still pushed
    add_row(SYM_MINUS, 0);
    add_row(SYM_PLUS, 0);
    add_row(SYM_XOR, 1);

    // build 2^31 from 128 * 128 * 128 * 128 * 8, then divide by the -1 of an empty pop
    add_row(DIGIT0 + 8'd128, 0);
    add_row(DIGIT0 + 8'd128, 0);
    add_row(SYM_STAR, 0);
    add_row(DIGIT0 + 8'd128, 0);
    add_row(SYM_STAR, 0);
    add_row(DIGIT0 + 8'd128, 0);
    add_row(SYM_STAR, 0);
    add_row(DIGIT0 + 8'd8, 0);
    add_row(SYM_STAR, 0);
    add_typed(SYM_SLASH, '{value: 32'h8000_0000, uf: 1'b1, ovf: 1'b0, dz: 1'b0});

    // fill the stack with both code extremes, drop one push, then divide 207 by zero
    add_row(8'h00, 0);
    repeat (13) add_row(DIGIT0 + 8'd3, 0);
    add_row(DIGIT0, 0);
    add_row(8'hFF, 0);
    add_row(DIGIT0 + 8'd9, 0);
    add_typed(SYM_SLASH, '{value: 32'd0, uf: 1'b0, ovf: 1'b1, dz: 1'b1});

    while (rst) @(posedge clk);

    gap_pct = 30;
    foreach (directed_rows[i])
      send_item(directed_rows[i].sym, directed_rows[i].lst, directed_rows[i].typed,
                directed_rows[i].ans);
    expressions = 3;

    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= ITEM_TARGET - TAIL_ITEMS) quiet_tail = 1;
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 15;
        default: gap_pct = 50;
      endcase
      build_expression();
      foreach (expr_syms[k])
        send_item(expr_syms[k], k == expr_syms.size() - 1, 1'b0, none);
      expressions++;
    end
    in_valid <= 1'b0;

    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d characters in %0d expressions, %0d answers checked", items_sent,
             expressions, answers_checked);
    $display("answers flagged: %0d underflow, %0d overflow, %0d divide by zero",
             uf_answers, ovf_answers, dz_answers);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
